// File: rtl/mtsb_pkg.sv
// Package for the toggle-gesture mode switch with pattern blinker.
// Field widths, register reset values, register indexes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package mtsb_pkg;

  localparam int WinW    = 16;
  localparam int StepW   = 8;
  localparam int PatW    = 34;
  localparam int EdgeW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = PatW;

  localparam int PatternLengthDefault = 34;

  localparam logic [WinW-1:0]  WinReset  = 16'd300;
  localparam logic [StepW-1:0] StepReset = 8'd100;
  localparam logic [PatW-1:0]  PatReset  = 34'd88569621;
  localparam logic [EdgeW-1:0] EdgeLimit = 3'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWindow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStep    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPattern = 2'd2;

  typedef struct packed {
    logic [WinW-1:0]  window;
    logic [StepW-1:0] step;
    logic [PatW-1:0]  pattern;
  } cfg_t;

  // per-tick state, the pattern position travels separately
  typedef struct packed {
    logic             light_prev;
    logic [WinW-1:0]  countdown;
    logic [EdgeW-1:0] edge_cnt;
    logic             mode;
    logic [StepW-1:0] presc;
    logic             led;
  } state_t;

endpackage

// File: rtl/mtsb_core.sv
// Next-state logic for one tick: edge counting, mode toggle, blink stepping.
// Depends on mtsb_pkg.
`timescale 1ns / 1ps

module mtsb_core #(
  parameter int PATTERN_LENGTH = mtsb_pkg::PatternLengthDefault,
  parameter int PosW           = $clog2(PATTERN_LENGTH)
) (
  input  mtsb_pkg::cfg_t   cfg_i,
  input  mtsb_pkg::state_t state_i,
  input  logic [PosW-1:0]  pos_i,
  input  logic             light_pin_i,
  output mtsb_pkg::state_t state_o,
  output logic [PosW-1:0]  pos_o
);
  import mtsb_pkg::*;

  localparam int ExtW = ((1 << PosW) > PatW) ? (1 << PosW) : PatW;
  localparam int IdxW = $clog2(ExtW);

  logic            light;
  logic [ExtW-1:0] pat_ext;

  assign light   = ~light_pin_i;
  // positions past the pattern register read as zero
  assign pat_ext = ExtW'(cfg_i.pattern);

  always_comb begin
    state_o = state_i;
    pos_o   = pos_i;

    if (light != state_i.light_prev) begin
      state_o.countdown = cfg_i.window;
      state_o.edge_cnt  = state_i.edge_cnt + 1'b1;
    end

    if (state_o.edge_cnt > EdgeLimit) begin
      state_o.mode     = ~state_i.mode;
      state_o.edge_cnt = '0;
    end

    // expire the gesture once the window runs out
    if (state_o.countdown != '0) begin
      state_o.countdown = state_o.countdown - 1'b1;
    end else begin
      state_o.edge_cnt = '0;
    end

    if (!state_o.mode) begin
      state_o.led = 1'b0;
    end else begin
      if (state_i.presc == cfg_i.step) begin
        state_o.presc = '0;
        state_o.led   = pat_ext[IdxW'(pos_i)];
        if (pos_i == PosW'(PATTERN_LENGTH - 1)) begin
          pos_o = '0;
        end else begin
          pos_o = pos_i + 1'b1;
        end
      end
      state_o.presc = state_o.presc + 1'b1;
    end

    state_o.light_prev = light;
  end

endmodule

// File: rtl/multi_toggle_mode_switch_with_blinker.sv
// Toggle-gesture mode switch with pattern blinker, top level.
// A word passes the input register, then the result register, to the result ports.
// Throughput: one tick word per cycle while the result side is not stalled.
// Reset (rst_ni low, asynchronous): state cleared (LED off, mode disabled),
// registers at defaults, both pipeline registers empty; mode_q, led_q not reset.
`timescale 1ns / 1ps

module multi_toggle_mode_switch_with_blinker #(
  parameter int PATTERN_LENGTH = mtsb_pkg::PatternLengthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         light_pin_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         mode_enabled_o,
  output logic                         led_on_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mtsb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mtsb_pkg::CfgDatW-1:0] cfg_data_i
);
  import mtsb_pkg::*;

  localparam int PosW = $clog2(PATTERN_LENGTH);

  cfg_t            cfg_q;
  state_t          state_q, state_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            in_valid_q;
  logic            pin_q;
  logic            out_valid_q;
  logic            mode_q, led_q;
  logic            out_free;
  logic            advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window  <= WinReset;
      cfg_q.step    <= StepReset;
      cfg_q.pattern <= PatReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgWindow:  cfg_q.window  <= cfg_data_i[WinW-1:0];
        CfgStep:    cfg_q.step    <= cfg_data_i[StepW-1:0];
        CfgPattern: cfg_q.pattern <= cfg_data_i[PatW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pin_q <= light_pin_i;
    end
  end

  mtsb_core #(
    .PATTERN_LENGTH(PATTERN_LENGTH),
    .PosW          (PosW)
  ) u_core (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .pos_i      (pos_q),
    .light_pin_i(pin_q),
    .state_o    (state_d),
    .pos_o      (pos_d)
  );

  // state advances only as a word moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      pos_q   <= '0;
    end else if (advance) begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_q <= state_d.mode;
      led_q  <= state_d.led;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign mode_enabled_o = mode_q;
  assign led_on_o       = led_q;

endmodule

// File: rtl/mtsb_checker.sv
// Port-level checks for the mode switch with blinker, bound to the top level.
// Depends on multi_toggle_mode_switch_with_blinker.
`timescale 1ns / 1ps

module mtsb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic mode_enabled_o,
  input logic led_on_o
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mode_enabled_o) && $stable(led_on_o))
    else $error("stalled result word changed");

  // drop the LED whenever the mode is disabled
  a_led_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mode_enabled_o |-> !led_on_o)
    else $error("LED lit while mode disabled");

  // stall the input only when the result side is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with result register free");

  // a word accepted while the output is not stalled, with no stall after it, reaches the output via the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted word did not reach the output");

endmodule

bind multi_toggle_mode_switch_with_blinker mtsb_checker u_mtsb_checker (.*);

// File: sim/mtsb_tick_checker.sv
// Checker for the toggle-gesture mode switch: watches the tick, result and register channels,
// predicts mode and LED level per accepted word and compares them in order.
// Depends on mtsb_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module mtsb_tick_checker #(
  parameter int PATTERN_LENGTH = mtsb_pkg::PatternLengthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         light_pin_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         mode_enabled_i,
  input  logic                         led_on_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [mtsb_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mtsb_pkg::CfgDatW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic mode_enabled;
    logic led_on;
  } indicator_t;

  indicator_t        indicators_due[$];
  mtsb_pkg::cfg_t    regs;
  mtsb_pkg::state_t  tick_state;
  logic [5:0]        position;
  int                fails;

  // one 1 ms tick of gesture detection and blinking
  task automatic predict_tick(input logic pin, output indicator_t res);
    logic light;
    int   next_pos;
    light = ~pin;
    if (light != tick_state.light_prev) begin
      tick_state.countdown = regs.window;
      tick_state.edge_cnt  = tick_state.edge_cnt + 1'b1;
    end
    if (tick_state.edge_cnt > mtsb_pkg::EdgeLimit) begin
      tick_state.mode     = ~tick_state.mode;
      tick_state.edge_cnt = '0;
    end
    // an expired window drops the edges gathered so far
    if (tick_state.countdown != '0) begin
      tick_state.countdown = tick_state.countdown - 1'b1;
    end else begin
      tick_state.edge_cnt = '0;
    end
    if (!tick_state.mode) begin
      tick_state.led = 1'b0;
    end else begin
      if (tick_state.presc == regs.step) begin
        tick_state.presc = '0;
        tick_state.led   = (position < mtsb_pkg::PatW) ? regs.pattern[position] : 1'b0;
        next_pos         = int'(position) + 1;
        position         = (next_pos >= PATTERN_LENGTH || next_pos > 63) ? 6'd0 : 6'(next_pos);
      end
      tick_state.presc = tick_state.presc + 1'b1;
    end
    tick_state.light_prev = light;
    res.mode_enabled      = tick_state.mode;
    res.led_on            = tick_state.led;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    indicator_t due;
    indicator_t seen;
    if (!rst_ni) begin
      regs.window  = mtsb_pkg::WinReset;
      regs.step    = mtsb_pkg::StepReset;
      regs.pattern = mtsb_pkg::PatReset;
      tick_state   = '0;
      position     = '0;
      fails        = 0;
      indicators_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          mtsb_pkg::CfgWindow:  regs.window  = cfg_data_i[mtsb_pkg::WinW-1:0];
          mtsb_pkg::CfgStep:    regs.step    = cfg_data_i[mtsb_pkg::StepW-1:0];
          mtsb_pkg::CfgPattern: regs.pattern = cfg_data_i;
          default: ;
        endcase
      end
      // retire the oldest expectation before queuing a new one
      if (out_valid_i && !out_stall_i) begin
        seen = '{mode_enabled: mode_enabled_i, led_on: led_on_i};
        if (indicators_due.size() == 0) begin
          if (fails < 10) begin
            $display("%0t: result word with nothing due: mode %b led %b",
                     $realtime, seen.mode_enabled, seen.led_on);
          end
          fails++;
        end else begin
          due = indicators_due.pop_front();
          if (due != seen) begin
            if (fails < 10) begin
              $display("%0t: mismatch: mode exp %b got %b, led exp %b got %b", $realtime,
                       due.mode_enabled, seen.mode_enabled, due.led_on, seen.led_on);
            end
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_tick(light_pin_i, due);
        indicators_due.push_back(due);
      end
      fail_count_o <= fails;
      pending_o    <= indicators_due.size();
    end
  end

endmodule

// File: sim/tb_multi_toggle_mode_switch_with_blinker.sv
// Testbench top for the toggle-gesture mode switch with pattern blinker: drives tick words
// and register writes, stalls the result side at random and gives the verdict.
// Depends on mtsb_pkg, the block itself and mtsb_tick_checker.
`timescale 1ns / 1ps

module tb_multi_toggle_mode_switch_with_blinker;

  localparam int CycleLimit = 200000;
  localparam int PhaseCount = 10;
  localparam int PatLength  = mtsb_pkg::PatternLengthDefault;
  // index with no register behind it
  localparam logic [mtsb_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  logic                         clk         = 1'b0;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         light_pin   = 1'b1;
  logic                         out_stall   = 1'b0;
  logic                         cfg_valid   = 1'b0;
  logic [mtsb_pkg::CfgIdxW-1:0] cfg_index   = '0;
  logic [mtsb_pkg::CfgDatW-1:0] cfg_data    = '0;
  logic                         in_stall;
  logic                         out_valid;
  logic                         mode_enabled;
  logic                         led_on;
  logic                         cfg_ready;
  int                           fail_count;
  int                           pending;
  int                           cycles      = 0;
  int                           ticks_sent  = 0;
  logic                         idle_on     = 1'b1;
  logic                         hold_off_req = 1'b0;
  logic                         hold_off_done = 1'b0;
  logic                         pin_level   = 1'b1;

  always #5 clk = ~clk;

  multi_toggle_mode_switch_with_blinker #(
    .PATTERN_LENGTH(PatLength)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .light_pin_i   (light_pin),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .mode_enabled_o(mode_enabled),
    .led_on_o      (led_on),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  mtsb_tick_checker #(
    .PATTERN_LENGTH(PatLength)
  ) i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .light_pin_i   (light_pin),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .mode_enabled_i(mode_enabled),
    .led_on_i      (led_on),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("multi_toggle_mode_switch_with_blinker test failed");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request, quiet stretches
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 40) == 0) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic pin);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    light_pin <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic hold_level(input int n);
    repeat (n) send_tick(pin_level);
  endtask

  // toggle the pin a number of times, holding it for up to max_gap ticks after each toggle
  task automatic send_gesture(input int edges, input int max_gap);
    repeat (edges) begin
      pin_level = ~pin_level;
      send_tick(pin_level);
      hold_level($urandom_range(0, max_gap));
    end
  endtask

  task automatic run_ticks(input int n);
    int target;
    target = ticks_sent + n;
    while (ticks_sent < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          send_gesture(4, 2);
          hold_level($urandom_range(3, 25));
        end
        6, 7: begin
          repeat ($urandom_range(1, 8)) begin
            pin_level = 1'($urandom_range(0, 1));
            send_tick(pin_level);
          end
        end
        default: begin
          send_gesture($urandom_range(1, 3), 4);
          hold_level($urandom_range(1, 10));
        end
      endcase
    end
  endtask

  task automatic write_reg(input logic [mtsb_pkg::CfgIdxW-1:0] idx,
                           input logic [mtsb_pkg::CfgDatW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // junk in the unused upper bits must be dropped by the block
  task automatic program_regs(input logic [mtsb_pkg::WinW-1:0]  win,
                              input logic [mtsb_pkg::StepW-1:0] step,
                              input logic [mtsb_pkg::PatW-1:0]  pattern,
                              input logic                       poke_unused);
    write_reg(mtsb_pkg::CfgWindow, {18'($urandom), win});
    write_reg(mtsb_pkg::CfgStep, {26'($urandom), step});
    write_reg(mtsb_pkg::CfgPattern, pattern);
    if (poke_unused) write_reg(CfgUnused, mtsb_pkg::CfgDatW'({$urandom, $urandom}));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [mtsb_pkg::WinW-1:0]  win;
    logic [mtsb_pkg::StepW-1:0] step;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: steady dark pin, then a fast gesture to enable
    hold_level(2);
    send_gesture(4, 0);
    hold_level(3);

    // zero window swallows every edge; step 0 steps the pattern only when the 8-bit prescaler wraps
    drain;
    program_regs('0, '0, '1, 1'b1);
    send_gesture(4, 0);
    hold_level(2);

    drain;
    program_regs('1, '1, '0, 1'b0);
    send_gesture(4, 1);
    hold_level(3);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      drain;
      idle_on = (ph < PhaseCount - 2);
      win  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
      step = ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      program_regs(win, step, mtsb_pkg::PatW'({$urandom, $urandom}), ph[0]);
      if (ph == 3) hold_off_req = 1'b1;
      run_ticks(52);
    end

    drain;
    if (fail_count == 0 && pending == 0) begin
      $display("multi_toggle_mode_switch_with_blinker test passed");
    end else begin
      $display("multi_toggle_mode_switch_with_blinker test failed");
    end
    $finish;
  end

endmodule
